@@ rtl/core/bgd_pkg.sv @@
package bgd_pkg;

  // Width of the elapsed-tick counters
  localparam int unsigned CounterWidth = 17;

  // Configuration port geometry
  localparam int unsigned RegAddrWidth = 4;
  localparam int unsigned RegDataWidth = 32;

  // Register reset values
  localparam logic [15:0] LongPressTicksRst   = 16'd1000;
  localparam logic [15:0] DoubleClickTicksRst = 16'd400;

  // Long-repeat visits before the wait-for-high-level flag is set
  localparam logic [1:0] RepeatLimit = 2'd2;

  // Event bit positions in event_mask
  localparam int unsigned EvPressed     = 0;
  localparam int unsigned EvPressing    = 1;
  localparam int unsigned EvReleased    = 2;
  localparam int unsigned EvClicked     = 3;
  localparam int unsigned EvDouble      = 4;
  localparam int unsigned EvLongPressed = 5;
  localparam int unsigned EvRepeat      = 6;
  localparam int unsigned EvLongClicked = 7;

  typedef enum logic [1:0] {
    REG_LONG_PRESS   = 2'd0,
    REG_DOUBLE_CLICK = 2'd1,
    REG_SEP_MODE     = 2'd2,
    REG_HANDLER      = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_STANDBY      = 3'd0,
    PH_PRESSED      = 3'd1,
    PH_PRESSING     = 3'd2,
    PH_LONGPRESSED  = 3'd3,
    PH_LONGPRESSING = 3'd4,
    PH_REPEAT       = 3'd5,
    PH_RELEASED     = 3'd6
  } phase_e;

  typedef struct packed {
    logic pin_edge;
    logic pin_level;
  } bgd_req_t;

  typedef struct packed {
    logic [7:0] event_mask;
    logic       is_pressing;
  } bgd_rsp_t;

  typedef struct packed {
    logic [15:0] long_press_ticks;
    logic [15:0] double_click_ticks;
    logic        separate_click_mode;
    logic [7:0]  handler_mask;
  } bgd_cfg_t;

endpackage

@@ rtl/core/bgd_regs.sv @@
module bgd_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bgd_pkg::RegAddrWidth-1:0]    paddr,
  input  logic [bgd_pkg::RegDataWidth-1:0]    pwdata,
  output logic [bgd_pkg::RegDataWidth-1:0]    prdata,
  output logic                                pready,
  output bgd_pkg::bgd_cfg_t                   cfg_o
);

  bgd_pkg::bgd_cfg_t cfg_q, cfg_d;
  bgd_pkg::reg_idx_e idx;
  logic              wr_en;

  assign idx    = bgd_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        bgd_pkg::REG_LONG_PRESS:   cfg_d.long_press_ticks    = pwdata[15:0];
        bgd_pkg::REG_DOUBLE_CLICK: cfg_d.double_click_ticks  = pwdata[15:0];
        bgd_pkg::REG_SEP_MODE:     cfg_d.separate_click_mode = pwdata[0];
        bgd_pkg::REG_HANDLER:      cfg_d.handler_mask        = pwdata[7:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bgd_pkg::REG_LONG_PRESS:   prdata = {16'd0, cfg_q.long_press_ticks};
      bgd_pkg::REG_DOUBLE_CLICK: prdata = {16'd0, cfg_q.double_click_ticks};
      bgd_pkg::REG_SEP_MODE:     prdata = {31'd0, cfg_q.separate_click_mode};
      bgd_pkg::REG_HANDLER:      prdata = {24'd0, cfg_q.handler_mask};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ticks    <= bgd_pkg::LongPressTicksRst;
      cfg_q.double_click_ticks  <= bgd_pkg::DoubleClickTicksRst;
      cfg_q.separate_click_mode <= 1'b0;
      cfg_q.handler_mask        <= 8'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ rtl/core/bgd_core.sv @@
module bgd_core #(
  parameter int unsigned CounterWidth = bgd_pkg::CounterWidth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  bgd_pkg::bgd_req_t req_i,
  input  bgd_pkg::bgd_cfg_t cfg_i,
  output bgd_pkg::bgd_rsp_t rsp_o
);

  localparam int unsigned CmpW = (CounterWidth > 16) ? CounterWidth : 16;

  bgd_pkg::phase_e phase_q, phase_d, phase_edge;

  logic [CounterWidth-1:0] hold_q, hold_d, hold_inc;
  logic [CounterWidth-1:0] click_q, click_d, click_inc;
  logic                    long_q, long_d;
  logic [1:0]              rep_q, rep_d;
  logic                    wait_q, wait_d;
  logic [1:0]              cnt_q, cnt_d;
  logic                    dbl_q, dbl_d;
  logic                    dfired_q, dfired_d;
  logic [7:0]              ev;
  logic                    skip_clicks;
  logic                    hold_reached;
  logic                    in_window;
  logic [7:0]              hm;

  assign hm        = cfg_i.handler_mask;
  assign hold_inc  = (hold_q == '1) ? hold_q : hold_q + 1'b1;
  assign click_inc = (click_q == '1) ? click_q : click_q + 1'b1;

  assign hold_reached = CmpW'(hold_inc) >= CmpW'(cfg_i.long_press_ticks);

  // Next phase: apply the pin edge, then one machine update
  always_comb begin
    phase_edge = phase_q;
    if (req_i.pin_edge) begin
      unique case (phase_q)
        bgd_pkg::PH_STANDBY:      phase_edge = bgd_pkg::PH_PRESSED;
        bgd_pkg::PH_PRESSED,
        bgd_pkg::PH_PRESSING,
        bgd_pkg::PH_LONGPRESSED,
        bgd_pkg::PH_LONGPRESSING,
        bgd_pkg::PH_REPEAT:       phase_edge = bgd_pkg::PH_RELEASED;
        default:                  phase_edge = phase_q;
      endcase
    end

    phase_d = phase_edge;
    unique case (phase_edge)
      bgd_pkg::PH_PRESSED:      phase_d = bgd_pkg::PH_PRESSING;
      bgd_pkg::PH_PRESSING:     if (hold_reached) phase_d = bgd_pkg::PH_LONGPRESSED;
      bgd_pkg::PH_LONGPRESSED:  phase_d = bgd_pkg::PH_LONGPRESSING;
      bgd_pkg::PH_REPEAT:       phase_d = bgd_pkg::PH_LONGPRESSING;
      bgd_pkg::PH_LONGPRESSING: if (hold_reached) phase_d = bgd_pkg::PH_REPEAT;
      bgd_pkg::PH_RELEASED: begin
        if (!wait_q || req_i.pin_level) phase_d = bgd_pkg::PH_STANDBY;
      end
      default:                  phase_d = phase_edge;
    endcase
  end

  // Events and bookkeeping for this tick
  always_comb begin
    hold_d      = hold_inc;
    click_d     = click_inc;
    long_d      = long_q;
    rep_d       = rep_q;
    wait_d      = wait_q;
    cnt_d       = cnt_q;
    dbl_d       = dbl_q;
    dfired_d    = dfired_q;
    ev          = '0;
    skip_clicks = 1'b0;
    in_window   = 1'b0;

    unique case (phase_edge)
      bgd_pkg::PH_PRESSED: begin
        hold_d        = '0;
        ev[bgd_pkg::EvPressed] = 1'b1;
        long_d        = 1'b0;
        rep_d         = 2'd0;
      end
      bgd_pkg::PH_PRESSING,
      bgd_pkg::PH_LONGPRESSING: begin
        ev[bgd_pkg::EvPressing] = 1'b1;
      end
      bgd_pkg::PH_LONGPRESSED: begin
        hold_d = '0;
        long_d = 1'b1;
        ev[bgd_pkg::EvLongPressed] = 1'b1;
      end
      bgd_pkg::PH_REPEAT: begin
        hold_d = '0;
        long_d = 1'b1;
        if (rep_q < bgd_pkg::RepeatLimit) begin
          rep_d = rep_q + 2'd1;
        end else begin
          rep_d  = 2'd0;
          wait_d = 1'b1;
        end
        ev[bgd_pkg::EvRepeat] = 1'b1;
      end
      bgd_pkg::PH_RELEASED: begin
        if (wait_q) begin
          // Hold in released until the pin reads high
          if (req_i.pin_level) begin
            wait_d = 1'b0;
            ev[bgd_pkg::EvReleased] = 1'b1;
          end
          skip_clicks = 1'b1;
        end else begin
          if (dfired_q) begin
            ev[bgd_pkg::EvReleased] = 1'b1;
            dfired_d = 1'b0;
          end
          if (dbl_q) dbl_d = 1'b0;
          else       ev[bgd_pkg::EvReleased] = 1'b1;
          if (long_q && hm[bgd_pkg::EvLongClicked]) begin
            ev[bgd_pkg::EvLongClicked] = 1'b1;
            long_d = 1'b0;
          end else if (cfg_i.separate_click_mode || !long_q ||
                       !hm[bgd_pkg::EvLongPressed]) begin
            // Register one click
            if (cnt_q == 2'd0) begin
              cnt_d   = 2'd1;
              click_d = '0;
            end else if (CmpW'(click_inc) <= CmpW'(cfg_i.double_click_ticks)) begin
              cnt_d = cnt_q + 2'd1;
            end else begin
              cnt_d   = 2'd1;
              click_d = '0;
              dbl_d   = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase

    in_window = CmpW'(click_d) <= CmpW'(cfg_i.double_click_ticks);

    if (!skip_clicks) begin
      if (cnt_d == 2'd1) begin
        if (!hm[bgd_pkg::EvDouble]) begin
          ev[bgd_pkg::EvClicked] = 1'b1;
          cnt_d = 2'd0;
        end else if (hm[bgd_pkg::EvClicked] && !in_window && !dbl_d) begin
          ev[bgd_pkg::EvClicked] = 1'b1;
          cnt_d = 2'd0;
        end
      end else if (cnt_d == 2'd2) begin
        if (hm[bgd_pkg::EvDouble]) begin
          ev[bgd_pkg::EvDouble] = 1'b1;
          dfired_d = 1'b1;
        end
        dbl_d = 1'b1;
        cnt_d = 2'd0;
      end
    end
  end

  assign rsp_o.event_mask  = ev & hm;
  assign rsp_o.is_pressing = (phase_d == bgd_pkg::PH_PRESSING) ||
                             (phase_d == bgd_pkg::PH_LONGPRESSING);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= bgd_pkg::PH_STANDBY;
      hold_q   <= '0;
      click_q  <= '0;
      long_q   <= 1'b0;
      rep_q    <= 2'd0;
      wait_q   <= 1'b0;
      cnt_q    <= 2'd0;
      dbl_q    <= 1'b0;
      dfired_q <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      hold_q   <= hold_d;
      click_q  <= click_d;
      long_q   <= long_d;
      rep_q    <= rep_d;
      wait_q   <= wait_d;
      cnt_q    <= cnt_d;
      dbl_q    <= dbl_d;
      dfired_q <= dfired_d;
    end
  end

  a_wait_implies_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wait_q |-> long_q)
    else $error("wait-for-high flag set without long press");

  a_repeat_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_q != 2'd3)
    else $error("repeat count past its limit");

endmodule

@@ rtl/core/button_gesture_detector_unit.sv @@
// Button gesture detector: one request per one-millisecond tick.
// Input channel (in_valid_i / in_stall_o / in_req_i) carries the pin-change
// flag and the current pin level. Output channel (out_valid_o / out_stall_i /
// out_rsp_o) returns one response per request: the event mask (pressed,
// pressing, released, clicked, double, long-pressed, repeat, long-clicked),
// gated by handler_mask, and the is-pressing flag.
// Path: a request waits in the input register, then in the response register.
// Throughput: one request per cycle while out_stall_i is low; the tick
// update is a single pass of logic between the input and response registers.
// Stall: while out_stall_i holds a pending response, the input register
// keeps one more request and then in_stall_o rises; nothing is dropped.
// Reset (rst_ni low, asynchronous): phase returns to standby, all counters
// and flags clear, registers take their defaults (long press 1000 ticks,
// double-click window 400 ticks, separate-click off, no handlers).
// Configuration goes through the APB port, registers at byte offsets
// 0, 4, 8, 12; write only while no request is in flight.
module button_gesture_detector_unit #(
  parameter int unsigned CounterWidth = bgd_pkg::CounterWidth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  bgd_pkg::bgd_req_t                in_req_i,
  // response channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output bgd_pkg::bgd_rsp_t                out_rsp_o,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bgd_pkg::RegAddrWidth-1:0] paddr,
  input  logic [bgd_pkg::RegDataWidth-1:0] pwdata,
  output logic [bgd_pkg::RegDataWidth-1:0] prdata,
  output logic                             pready
);

  bgd_pkg::bgd_cfg_t cfg;
  bgd_pkg::bgd_req_t in_req_q;
  bgd_pkg::bgd_rsp_t step_rsp;
  bgd_pkg::bgd_rsp_t out_rsp_q;
  logic              in_valid_q, in_valid_d;
  logic              out_valid_q, out_valid_d;
  logic              advance;
  logic              in_accept;

  bgd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Advance the held request into the response register when that slot is
  // free or being drained this cycle.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  bgd_core #(
    .CounterWidth (CounterWidth)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .req_i  (in_req_q),
    .cfg_i  (cfg),
    .rsp_o  (step_rsp)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept)    in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance)           out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload: hold the request until it steps, hold the response until taken
  always_ff @(posedge clk_i) begin
    if (in_accept) in_req_q  <= in_req_i;
    if (advance)   out_rsp_q <= step_rsp;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  a_stall_needs_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q)
    else $error("input stalled with a free pipeline slot");

  a_held_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && out_stall_i |=> in_valid_q)
    else $error("held request lost under output stall");

  a_pressed_implies_pressing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_rsp_q.event_mask[bgd_pkg::EvPressed] |-> out_rsp_q.is_pressing)
    else $error("pressed event without pressing phase");

  a_released_not_pressing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_rsp_q.event_mask[bgd_pkg::EvReleased] |-> !out_rsp_q.is_pressing)
    else $error("released event while still pressing");

endmodule
